// ===== rtl/core/segment_pair_clearance_3d_defines.svh =====
// ----------------------------------------------------------------------------
// segment_pair_clearance_3d_defines
// Assertion macros shared by the clearance block.
// ----------------------------------------------------------------------------
`ifndef SEGMENT_PAIR_CLEARANCE_3D_DEFINES_SVH
`define SEGMENT_PAIR_CLEARANCE_3D_DEFINES_SVH

// same-cycle implication, disabled during reset
`define SCP_ASSERT_HOLD(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define SCP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/scp_pkg.sv =====
// ----------------------------------------------------------------------------
// scp_pkg
// Widths, constants and payload types of the segment clearance block.
// ----------------------------------------------------------------------------
package scp_pkg;

   // coordinate and projection format
   localparam int CW     = 24;
   localparam int PF     = 16;
   // derived widths
   localparam int DW     = CW + 1;         // coordinate difference, signed
   localparam int LEN_W  = 2 * DW;         // squared length, unsigned
   localparam int DOT_W  = 2 * DW + 2;     // dot product, signed
   localparam int REM_W  = LEN_W + 1;      // divider remainder
   localparam int T_W    = PF + 1;         // clamped projection parameter
   localparam int TD_W   = DW + T_W + 1;   // t * d, signed
   localparam int EW     = DW + PF + 2;    // residual, signed
   localparam int EM     = EW - 1;         // residual magnitude
   localparam int EL     = EM / 2;         // low split of magnitude
   localparam int EH     = EM - EL;        // high split of magnitude
   localparam int SQ_W   = 2 * EM + 2;     // squared residual length
   localparam int RT_W   = SQ_W / 2;       // square root width
   localparam int DMAX_W = RT_W - PF;      // distance before saturation
   localparam int DIST_W = 25;

   localparam logic [T_W-1:0]    T_ONE     = T_W'(1) << PF;
   localparam logic [DIST_W-1:0] DIST_MAX  = '1;
   localparam logic [DIST_W-1:0] CLR_RESET = DIST_W'(512);

   typedef logic signed [CW-1:0] coord_type;
   typedef logic [DIST_W-1:0]    dist_type;

   typedef struct packed {
      coord_type x;
      coord_type y;
      coord_type z;
   } point_type;

   typedef struct packed {
      coord_type seg_a_start_x;
      coord_type seg_a_start_y;
      coord_type seg_a_start_z;
      coord_type seg_a_end_x;
      coord_type seg_a_end_y;
      coord_type seg_a_end_z;
      coord_type seg_b_start_x;
      coord_type seg_b_start_y;
      coord_type seg_b_start_z;
      coord_type seg_b_end_x;
      coord_type seg_b_end_y;
      coord_type seg_b_end_z;
   } req_type;

   typedef struct packed {
      dist_type min_distance;
      logic     too_close;
   } rsp_type;

endpackage

// ===== rtl/core/scp_proj.sv =====
// ----------------------------------------------------------------------------
// scp_proj
// Point to segment projection: clamped t, residual and its squared length.
// ----------------------------------------------------------------------------
module scp_proj (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      en,
   input  logic                      in_v,
   input  scp_pkg::point_type        p,
   input  scp_pkg::point_type        s1,
   input  scp_pkg::point_type        s2,
   output logic                      out_v,
   output logic [scp_pkg::SQ_W-1:0]  sq
);

   localparam int DW    = scp_pkg::DW;
   localparam int PF    = scp_pkg::PF;
   localparam int CW    = scp_pkg::CW;
   localparam int LEN_W = scp_pkg::LEN_W;
   localparam int DOT_W = scp_pkg::DOT_W;
   localparam int REM_W = scp_pkg::REM_W;
   localparam int T_W   = scp_pkg::T_W;
   localparam int TD_W  = scp_pkg::TD_W;
   localparam int EW    = scp_pkg::EW;
   localparam int EM    = scp_pkg::EM;
   localparam int EL    = scp_pkg::EL;
   localparam int EH    = scp_pkg::EH;
   localparam int SQ_W  = scp_pkg::SQ_W;

   logic signed [CW-1:0] pc [3];
   logic signed [CW-1:0] ac [3];
   logic signed [CW-1:0] bc [3];

   assign pc[0] = p.x;
   assign pc[1] = p.y;
   assign pc[2] = p.z;
   assign ac[0] = s1.x;
   assign ac[1] = s1.y;
   assign ac[2] = s1.z;
   assign bc[0] = s2.x;
   assign bc[1] = s2.y;
   assign bc[2] = s2.z;

   // stage 1: direction d and offset w
   logic signed [DW-1:0] d1_in [3];
   logic signed [DW-1:0] w1_in [3];
   logic signed [DW-1:0] d1_ff [3];
   logic signed [DW-1:0] w1_ff [3];
   logic                 v1_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         d1_in[i] = {bc[i][CW-1], bc[i]} - {ac[i][CW-1], ac[i]};
         w1_in[i] = {pc[i][CW-1], pc[i]} - {ac[i][CW-1], ac[i]};
      end
   end

   // stage 2: per-axis products
   logic signed [2*DW-1:0] dd2_in [3];
   logic signed [2*DW-1:0] wd2_in [3];
   logic        [LEN_W-1:0] dd2_ff [3];
   logic signed [2*DW-1:0] wd2_ff [3];
   logic signed [DW-1:0]   d2_ff [3];
   logic signed [DW-1:0]   w2_ff [3];
   logic                   v2_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         dd2_in[i] = d1_ff[i] * d1_ff[i];
         wd2_in[i] = w1_ff[i] * d1_ff[i];
      end
   end

   // stage 3: squared length and dot product
   logic        [LEN_W-1:0] len3_in;
   logic signed [DOT_W-1:0] dot3_in;
   logic        [LEN_W-1:0] len3_ff;
   logic signed [DOT_W-1:0] dot3_ff;
   logic signed [DW-1:0]    d3_ff [3];
   logic signed [DW-1:0]    w3_ff [3];
   logic                    v3_ff;

   assign len3_in = dd2_ff[0] + dd2_ff[1] + dd2_ff[2];
   assign dot3_in = wd2_ff[0] + wd2_ff[1] + wd2_ff[2];

   // stage 4: clamp decision, divider seed
   logic             pos4;
   logic             ge4;
   logic [REM_W-1:0] r4_in;

   assign pos4  = dot3_ff > 0;
   assign ge4   = $unsigned(dot3_ff) >= DOT_W'(len3_ff);
   assign r4_in = (pos4 && !ge4) ? dot3_ff[REM_W-1:0] : '0;

   // divider pipeline, one quotient bit per stage
   logic [REM_W-1:0]     rq_ff  [PF+1];
   logic [PF-1:0]        qq_ff  [PF+1];
   logic [LEN_W-1:0]     lq_ff  [PF+1];
   logic                 zq_ff  [PF+1];
   logic                 oq_ff  [PF+1];
   logic                 vq_ff  [PF+1];
   logic signed [DW-1:0] dq_ff  [PF+1][3];
   logic signed [DW-1:0] wq_ff  [PF+1][3];

   logic [REM_W-1:0] rs_c [PF];
   logic             gq_c [PF];

   always_comb begin
      for (int k = 0; k < PF; k++) begin
         rs_c[k] = {rq_ff[k][REM_W-2:0], 1'b0};
         gq_c[k] = rs_c[k] >= {1'b0, lq_ff[k]};
      end
   end

   // stage 5: clamped t, then t*d and w scaled
   logic [T_W-1:0]        t5;
   logic signed [TD_W-1:0] td5_in [3];
   logic signed [EW-1:0]   ws5_in [3];
   logic signed [TD_W-1:0] td5_ff [3];
   logic signed [EW-1:0]   ws5_ff [3];
   logic                   v5_ff;

   always_comb begin
      if (zq_ff[PF]) begin
         t5 = '0;
      end else if (oq_ff[PF]) begin
         t5 = scp_pkg::T_ONE;
      end else begin
         t5 = {1'b0, qq_ff[PF]};
      end
      for (int i = 0; i < 3; i++) begin
         td5_in[i] = $signed({1'b0, t5}) * dq_ff[PF][i];
         ws5_in[i] = EW'(wq_ff[PF][i]) <<< PF;
      end
   end

   // stage 6: residual magnitude
   logic signed [EW-1:0] e6_c  [3];
   logic signed [EW-1:0] ea6_c [3];
   logic [EM-1:0]        em6_ff [3];
   logic                 v6_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         e6_c[i]  = ws5_ff[i] - EW'(td5_ff[i]);
         ea6_c[i] = e6_c[i][EW-1] ? -e6_c[i] : e6_c[i];
      end
   end

   // stage 7: partial products of the square
   logic [2*EH-1:0]  hh7_ff [3];
   logic [EH+EL-1:0] hl7_ff [3];
   logic [2*EL-1:0]  ll7_ff [3];
   logic             v7_ff;

   // stage 8: per-axis square, stage 9: sum over axes
   logic [SQ_W-1:0] ax8_ff [3];
   logic            v8_ff;
   logic [SQ_W-1:0] sq9_ff;
   logic            v9_ff;

   // data registers
   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            d1_ff[i]  <= d1_in[i];
            w1_ff[i]  <= w1_in[i];
            dd2_ff[i] <= dd2_in[i][LEN_W-1:0];
            wd2_ff[i] <= wd2_in[i];
            d2_ff[i]  <= d1_ff[i];
            w2_ff[i]  <= w1_ff[i];
            d3_ff[i]  <= d2_ff[i];
            w3_ff[i]  <= w2_ff[i];
            dq_ff[0][i] <= d3_ff[i];
            wq_ff[0][i] <= w3_ff[i];
            td5_ff[i] <= td5_in[i];
            ws5_ff[i] <= ws5_in[i];
            em6_ff[i] <= ea6_c[i][EM-1:0];
            hh7_ff[i] <= em6_ff[i][EM-1:EL] * em6_ff[i][EM-1:EL];
            hl7_ff[i] <= em6_ff[i][EM-1:EL] * em6_ff[i][EL-1:0];
            ll7_ff[i] <= em6_ff[i][EL-1:0] * em6_ff[i][EL-1:0];
            ax8_ff[i] <= (SQ_W'(hh7_ff[i]) << (2 * EL))
                       + (SQ_W'(hl7_ff[i]) << (EL + 1))
                       + SQ_W'(ll7_ff[i]);
         end
         len3_ff  <= len3_in;
         dot3_ff  <= dot3_in;
         rq_ff[0] <= r4_in;
         qq_ff[0] <= '0;
         lq_ff[0] <= len3_ff;
         zq_ff[0] <= !pos4;
         oq_ff[0] <= pos4 && ge4;
         for (int k = 0; k < PF; k++) begin
            rq_ff[k+1] <= gq_c[k] ? rs_c[k] - {1'b0, lq_ff[k]} : rs_c[k];
            qq_ff[k+1] <= {qq_ff[k][PF-2:0], gq_c[k]};
            lq_ff[k+1] <= lq_ff[k];
            zq_ff[k+1] <= zq_ff[k];
            oq_ff[k+1] <= oq_ff[k];
            for (int i = 0; i < 3; i++) begin
               dq_ff[k+1][i] <= dq_ff[k][i];
               wq_ff[k+1][i] <= wq_ff[k][i];
            end
         end
         sq9_ff <= ax8_ff[0] + ax8_ff[1] + ax8_ff[2];
      end
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         for (int k = 0; k <= PF; k++) begin
            vq_ff[k] <= 1'b0;
         end
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
         v7_ff <= 1'b0;
         v8_ff <= 1'b0;
         v9_ff <= 1'b0;
      end else if (en) begin
         v1_ff    <= in_v;
         v2_ff    <= v1_ff;
         v3_ff    <= v2_ff;
         vq_ff[0] <= v3_ff;
         for (int k = 0; k < PF; k++) begin
            vq_ff[k+1] <= vq_ff[k];
         end
         v5_ff <= vq_ff[PF];
         v6_ff <= v5_ff;
         v7_ff <= v6_ff;
         v8_ff <= v7_ff;
         v9_ff <= v8_ff;
      end
   end

   assign out_v = v9_ff;
   assign sq    = sq9_ff;

endmodule

// ===== rtl/core/scp_isqrt.sv =====
// ----------------------------------------------------------------------------
// scp_isqrt
// Pipelined integer square root, one root bit per stage.
// ----------------------------------------------------------------------------
module scp_isqrt (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      en,
   input  logic                      in_v,
   input  logic [scp_pkg::SQ_W-1:0]  n,
   output logic                      out_v,
   output logic [scp_pkg::RT_W-1:0]  root
);

   localparam int SQ_W = scp_pkg::SQ_W;
   localparam int RT_W = scp_pkg::RT_W;

   logic [SQ_W-1:0] n_ff   [RT_W];
   logic [RT_W+1:0] rem_ff [RT_W];
   logic [RT_W-1:0] rt_ff  [RT_W];
   logic            v_ff   [RT_W];

   for (genvar k = 0; k < RT_W; k++) begin : g_step
      logic [SQ_W-1:0] nk;
      logic [RT_W+1:0] remk;
      logic [RT_W-1:0] rtk;
      logic            vk;
      logic [RT_W+1:0] rs;
      logic [RT_W+1:0] trial;
      logic            ge;

      // stage inputs: module input or previous stage
      if (k == 0) begin : g_first
         assign nk   = n;
         assign remk = '0;
         assign rtk  = '0;
         assign vk   = in_v;
      end else begin : g_next
         assign nk   = n_ff[k-1];
         assign remk = rem_ff[k-1];
         assign rtk  = rt_ff[k-1];
         assign vk   = v_ff[k-1];
      end

      // bring down two bits, try root*4+1
      assign rs    = {remk[RT_W-1:0], nk[SQ_W-1:SQ_W-2]};
      assign trial = {rtk, 2'b01};
      assign ge    = rs >= trial;

      always_ff @(posedge clock) begin
         if (en) begin
            n_ff[k]   <= {nk[SQ_W-3:0], 2'b00};
            rem_ff[k] <= ge ? rs - trial : rs;
            rt_ff[k]  <= {rtk[RT_W-2:0], ge};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k] <= 1'b0;
         end else if (en) begin
            v_ff[k] <= vk;
         end
      end
   end

   assign out_v = v_ff[RT_W-1];
   assign root  = rt_ff[RT_W-1];

endmodule

// ===== rtl/core/segment_pair_clearance_3d.sv =====
// ----------------------------------------------------------------------------
// segment_pair_clearance_3d
// Minimum endpoint-to-segment distance of two 3D segments, with clearance flag.
// ----------------------------------------------------------------------------
// The block takes one segment pair per clock while req_ready is high and returns
// one result per pair, in order. Each pair passes 25 stages of projection
// (products, a 16-stage restoring divider for the clamped projection parameter,
// residual and its square), 43 stages of the bit-per-stage square root, one
// stage for the minimum of the four distances and the output register. All four
// endpoint distances run in parallel units. A skid register behind the output
// keeps one more result, so req_ready falls only once both are full. The
// clearance register resets to 512 and is written through csr_we / csr_wdata;
// write it only while no item is in flight, the block does not enforce this.
// ----------------------------------------------------------------------------
`include "segment_pair_clearance_3d_defines.svh"

module segment_pair_clearance_3d (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  scp_pkg::req_type                req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output scp_pkg::rsp_type                rsp_data,
   input  logic                            csr_we,
   input  logic [scp_pkg::DIST_W-1:0]      csr_wdata
);

   localparam int SQ_W   = scp_pkg::SQ_W;
   localparam int RT_W   = scp_pkg::RT_W;
   localparam int PF     = scp_pkg::PF;
   localparam int DMAX_W = scp_pkg::DMAX_W;
   localparam int DIST_W = scp_pkg::DIST_W;

   logic                    en;
   logic                    skid_v_ff;
   logic                    rsp_v_ff;
   scp_pkg::rsp_type        rsp_ff;
   scp_pkg::rsp_type        skid_ff;
   logic [DIST_W-1:0]       clearance_ff;

   // pipeline advances unless the skid holds a result
   assign en        = !skid_v_ff;
   assign req_ready = en;

   // clearance register
   always_ff @(posedge clock) begin
      if (reset) begin
         clearance_ff <= scp_pkg::CLR_RESET;
      end else if (csr_we) begin
         clearance_ff <= csr_wdata;
      end
   end

   // endpoints and segments
   scp_pkg::point_type pa1, pa2, pb1, pb2;

   assign pa1 = '{req_data.seg_a_start_x, req_data.seg_a_start_y, req_data.seg_a_start_z};
   assign pa2 = '{req_data.seg_a_end_x, req_data.seg_a_end_y, req_data.seg_a_end_z};
   assign pb1 = '{req_data.seg_b_start_x, req_data.seg_b_start_y, req_data.seg_b_start_z};
   assign pb2 = '{req_data.seg_b_end_x, req_data.seg_b_end_y, req_data.seg_b_end_z};

   scp_pkg::point_type pp [4];
   scp_pkg::point_type ps1 [4];
   scp_pkg::point_type ps2 [4];

   assign pp[0] = pa1;  assign ps1[0] = pb1;  assign ps2[0] = pb2;
   assign pp[1] = pa2;  assign ps1[1] = pb1;  assign ps2[1] = pb2;
   assign pp[2] = pb1;  assign ps1[2] = pa1;  assign ps2[2] = pa2;
   assign pp[3] = pb2;  assign ps1[3] = pa1;  assign ps2[3] = pa2;

   logic              in_v;
   logic [SQ_W-1:0]   sq   [4];
   logic              sq_v [4];
   logic [RT_W-1:0]   rt   [4];
   logic              rt_v [4];

   assign in_v = req_valid && en;

   // four endpoint distance units
   for (genvar u = 0; u < 4; u++) begin : g_unit
      scp_proj u_proj (
         .clock (clock),
         .reset (reset),
         .en    (en),
         .in_v  (in_v),
         .p     (pp[u]),
         .s1    (ps1[u]),
         .s2    (ps2[u]),
         .out_v (sq_v[u]),
         .sq    (sq[u])
      );

      scp_isqrt u_isqrt (
         .clock (clock),
         .reset (reset),
         .en    (en),
         .in_v  (sq_v[u]),
         .n     (sq[u]),
         .out_v (rt_v[u]),
         .root  (rt[u])
      );
   end

   // minimum of four, saturated to the field
   logic [DMAX_W-1:0] ep_dist [4];
   logic [DMAX_W-1:0] min01, min23, min_all;
   logic [DIST_W-1:0] m_ff;
   logic              m_v_ff;
   logic              fin_v;

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         ep_dist[i] = rt[i][RT_W-1:PF];
      end
      min01   = (ep_dist[1] < ep_dist[0]) ? ep_dist[1] : ep_dist[0];
      min23   = (ep_dist[3] < ep_dist[2]) ? ep_dist[3] : ep_dist[2];
      min_all = (min23 < min01) ? min23 : min01;
   end

   assign fin_v = rt_v[0] && rt_v[1] && rt_v[2] && rt_v[3];

   always_ff @(posedge clock) begin
      if (en) begin
         m_ff <= (min_all > DMAX_W'(scp_pkg::DIST_MAX)) ? scp_pkg::DIST_MAX
                                                       : min_all[DIST_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m_v_ff <= 1'b0;
      end else if (en) begin
         m_v_ff <= fin_v;
      end
   end

   // finished item with its flag
   scp_pkg::rsp_type fin_item;

   assign fin_item.min_distance = m_ff;
   assign fin_item.too_close    = m_ff < clearance_ff;

   // output register and skid
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else if (!rsp_v_ff || rsp_ready) begin
         if (skid_v_ff) begin
            rsp_v_ff  <= 1'b1;
            skid_v_ff <= 1'b0;
         end else begin
            rsp_v_ff <= m_v_ff;
         end
      end else if (m_v_ff && en) begin
         skid_v_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!rsp_v_ff || rsp_ready) begin
         rsp_ff <= skid_v_ff ? skid_ff : fin_item;
      end else if (m_v_ff && en) begin
         skid_ff <= fin_item;
      end
   end

   assign rsp_valid = rsp_v_ff;
   assign rsp_data  = rsp_ff;

   // skid only fills behind a waiting result
   `SCP_ASSERT_HOLD(a_skid_behind_rsp, clock, reset, skid_v_ff, rsp_v_ff, "skid full without output")
   // drained output with nothing finished goes empty
   `SCP_ASSERT_NEXT(a_drain_empty, clock, reset, rsp_v_ff && rsp_ready && !skid_v_ff && !m_v_ff, !rsp_v_ff, "result invented")
   // skid keeps its item while output stalls
   `SCP_ASSERT_NEXT(a_skid_hold, clock, reset, skid_v_ff && !rsp_ready, skid_v_ff, "skid item lost")

endmodule

// ===== tb/segment_clearance_checker.sv =====
// ----------------------------------------------------------------------------
// segment_clearance_checker
// Watches the request, response and register ports of the clearance block,
// computes the expected clearance of every accepted segment pair and compares
// each response against it, in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module segment_clearance_checker (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic                       req_ready,
   input  scp_pkg::req_type           req_data,
   input  logic                       rsp_valid,
   input  logic                       rsp_ready,
   input  scp_pkg::rsp_type           rsp_data,
   input  logic                       csr_we,
   input  logic [scp_pkg::DIST_W-1:0] csr_wdata,
   output int                         mismatch_count,
   output int                         results_pending
);

   localparam int PROJ_BITS = scp_pkg::PF;

   scp_pkg::dist_type        limit_shadow;
   scp_pkg::rsp_type         expected_clearances[$];

   // integer square root, floor
   function automatic logic [127:0] floor_sqrt(logic [127:0] n);
      logic [127:0] root;
      logic [127:0] bitpos;
      logic [127:0] trial;
      root   = '0;
      bitpos = 128'd1 << 126;
      while (bitpos != 0) begin
         trial = root + bitpos;
         if (n >= trial) begin
            n    = n - trial;
            root = (root >> 1) + bitpos;
         end else begin
            root = root >> 1;
         end
         bitpos = bitpos >> 2;
      end
      return root;
   endfunction

   // distance from point p to segment s1..s2, t clamped to 0..1
   function automatic logic [127:0] point_segment_dist(scp_pkg::point_type p,
                                                       scp_pkg::point_type s1,
                                                       scp_pkg::point_type s2);
      longint d[3];
      longint w[3];
      longint len;
      longint dot;
      longint t;
      longint e;
      logic signed [127:0] wide_dot;
      logic [127:0] sq;
      d[0] = longint'(s2.x) - longint'(s1.x);
      d[1] = longint'(s2.y) - longint'(s1.y);
      d[2] = longint'(s2.z) - longint'(s1.z);
      w[0] = longint'(p.x) - longint'(s1.x);
      w[1] = longint'(p.y) - longint'(s1.y);
      w[2] = longint'(p.z) - longint'(s1.z);
      len = 0;
      dot = 0;
      for (int i = 0; i < 3; i++) begin
         len += d[i] * d[i];
         dot += w[i] * d[i];
      end
      if (dot <= 0) begin
         t = 0;
      end else if (dot >= len) begin
         t = 64'd1 << PROJ_BITS;
      end else begin
         wide_dot = 128'(dot) <<< PROJ_BITS;
         t = longint'(wide_dot / 128'(len));
      end
      sq = '0;
      for (int i = 0; i < 3; i++) begin
         e  = (w[i] <<< PROJ_BITS) - t * d[i];
         sq = sq + 128'($signed(128'(e)) * $signed(128'(e)));
      end
      return floor_sqrt(sq) >> PROJ_BITS;
   endfunction

   // smallest of the four endpoint distances, saturated, with flag
   function automatic scp_pkg::rsp_type predict_clearance(scp_pkg::req_type r,
                                                         scp_pkg::dist_type limit_value);
      scp_pkg::point_type a1, a2, b1, b2;
      logic [127:0] m, v;
      scp_pkg::rsp_type res;
      a1 = '{r.seg_a_start_x, r.seg_a_start_y, r.seg_a_start_z};
      a2 = '{r.seg_a_end_x, r.seg_a_end_y, r.seg_a_end_z};
      b1 = '{r.seg_b_start_x, r.seg_b_start_y, r.seg_b_start_z};
      b2 = '{r.seg_b_end_x, r.seg_b_end_y, r.seg_b_end_z};
      m = point_segment_dist(a1, b1, b2);
      v = point_segment_dist(a2, b1, b2);
      if (v < m) m = v;
      v = point_segment_dist(b1, a1, a2);
      if (v < m) m = v;
      v = point_segment_dist(b2, a1, a2);
      if (v < m) m = v;
      if (m > 128'(scp_pkg::DIST_MAX)) m = 128'(scp_pkg::DIST_MAX);
      res.min_distance = scp_pkg::dist_type'(m);
      res.too_close    = (scp_pkg::dist_type'(m) < limit_value);
      return res;
   endfunction

   assign results_pending = expected_clearances.size();

   // register shadow, expectation queue and response compare
   always @(posedge clock) begin
      scp_pkg::rsp_type want;
      if (reset) begin
         limit_shadow = scp_pkg::CLR_RESET;
         mismatch_count = 0;
         expected_clearances.delete();
      end else begin
         if (req_valid && req_ready)
            expected_clearances.insert(expected_clearances.size(),
                                       predict_clearance(req_data, limit_shadow));
         if (rsp_valid && rsp_ready) begin
            if (expected_clearances.size() == 0) begin
               mismatch_count++;
               $display("%0t: unexpected response, actual dist=%0d flag=%0b", $time,
                        rsp_data.min_distance, rsp_data.too_close);
            end else begin
               want = expected_clearances.pop_front();
               if (rsp_data.min_distance !== want.min_distance) begin
                  mismatch_count++;
                  $display("%0t: min_distance expected %0d actual %0d", $time,
                           want.min_distance, rsp_data.min_distance);
               end
               if (rsp_data.too_close !== want.too_close) begin
                  mismatch_count++;
                  $display("%0t: too_close expected %0b actual %0b", $time,
                           want.too_close, rsp_data.too_close);
               end
            end
         end
         if (csr_we) limit_shadow = csr_wdata;
      end
   end

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Stimulus for the segment clearance block: directed corner pairs, then
// random pairs under three sender/receiver idling mixes and one long receiver
// stall, across several clearance settings. Checking is in the checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;

   typedef scp_pkg::coord_type crd_type;

   localparam int DRAIN_CYCLES = 100;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int LONG_STALL = 400;

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_ready;
   scp_pkg::req_type    req_data;
   logic                rsp_valid;
   logic                rsp_ready;
   scp_pkg::rsp_type    rsp_data;
   logic                csr_we;
   scp_pkg::dist_type   csr_wdata;
   int                  mismatch_count;
   int                  results_pending;

   int         sender_idle_pct;
   int         receiver_idle_pct;
   logic       long_stall_go;
   int         quiet_cycles;

   segment_pair_clearance_3d dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   segment_clearance_checker checker_inst (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_data        (req_data),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_data        (rsp_data),
      .csr_we          (csr_we),
      .csr_wdata       (csr_wdata),
      .mismatch_count  (mismatch_count),
      .results_pending (results_pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // receiver: random ready, plus one long hold-off on request
   initial begin
      int held;
      held = 0;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (long_stall_go && held < LONG_STALL) begin
            rsp_ready <= 1'b0;
            held++;
         end else begin
            rsp_ready <= ($urandom_range(99) >= receiver_idle_pct);
         end
      end
   end

   // watchdog on cycles without any accepted item
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_pair(scp_pkg::req_type pair);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= pair;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   // write the clearance once the pipeline is empty
   task automatic write_limit(scp_pkg::dist_type value);
      req_valid <= 1'b0;
      while (results_pending != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(negedge clock);
      csr_we    <= 1'b0;
   endtask

   function automatic crd_type rand_coord();
      return crd_type'($urandom);
   endfunction

   // coordinate near a base, small span
   function automatic crd_type near_coord(crd_type base, int span);
      return base + crd_type'($urandom_range(2 * span) - span);
   endfunction

   function automatic scp_pkg::req_type rand_pair();
      scp_pkg::req_type p;
      crd_type bx, by, bz;
      int span;
      int kind;
      kind = $urandom_range(9);
      if (kind < 3) begin
         p = {rand_coord(), rand_coord(), rand_coord(), rand_coord(), rand_coord(),
              rand_coord(), rand_coord(), rand_coord(), rand_coord(), rand_coord(),
              rand_coord(), rand_coord()};
      end else begin
         bx = rand_coord();
         by = rand_coord();
         bz = rand_coord();
         span = (kind < 7) ? 1000 : 20;
         p = {near_coord(bx, span), near_coord(by, span), near_coord(bz, span),
              near_coord(bx, span), near_coord(by, span), near_coord(bz, span),
              near_coord(bx, span), near_coord(by, span), near_coord(bz, span),
              near_coord(bx, span), near_coord(by, span), near_coord(bz, span)};
         // zero-length segments now and then
         if (kind == 9) begin
            p.seg_a_end_x = p.seg_a_start_x;
            p.seg_a_end_y = p.seg_a_start_y;
            p.seg_a_end_z = p.seg_a_start_z;
         end
         if (kind == 8) begin
            p.seg_b_end_x = p.seg_b_start_x;
            p.seg_b_end_y = p.seg_b_start_y;
            p.seg_b_end_z = p.seg_b_start_z;
         end
      end
      return p;
   endfunction

   function automatic scp_pkg::req_type uniform_pair(crd_type a1, crd_type a2, crd_type b1,
                                                     crd_type b2);
      return {a1, a1, a1, a2, a2, a2, b1, b1, b1, b2, b2, b2};
   endfunction

   initial begin
      crd_type lo, hi;
      scp_pkg::req_type p;
      lo = crd_type'(-8388608);
      hi = crd_type'(8388607);
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_we = 1'b0;
      csr_wdata = '0;
      long_stall_go = 1'b0;
      sender_idle_pct = 0;
      receiver_idle_pct = 0;
      repeat (12) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed corners at the reset clearance
      send_pair(uniform_pair(lo, hi, lo, hi));
      send_pair(uniform_pair(lo, hi, hi, lo));
      send_pair(uniform_pair(lo, lo, hi, hi));
      send_pair(uniform_pair(hi, hi, lo, lo));
      send_pair(uniform_pair(crd_type'(0), crd_type'(0), crd_type'(0), crd_type'(0)));
      send_pair(uniform_pair(crd_type'(0), crd_type'(0), crd_type'(1), crd_type'(1)));
      send_pair(uniform_pair(crd_type'(0), crd_type'(0), crd_type'(2), crd_type'(2)));
      send_pair(uniform_pair(lo, lo, lo, lo));
      send_pair(uniform_pair(crd_type'(0), crd_type'(1000), crd_type'(500),
                             crd_type'(2000)));
      send_pair(uniform_pair(crd_type'(0), crd_type'(1000), crd_type'(-5000),
                             crd_type'(-300)));
      send_pair(uniform_pair(crd_type'(0), crd_type'(1000), crd_type'(1300),
                             crd_type'(9000)));
      p = '0;
      p.seg_a_end_x = crd_type'(100000);
      p.seg_b_start_x = crd_type'(50000);
      p.seg_b_start_y = crd_type'(200);
      p.seg_b_end_x = crd_type'(60000);
      p.seg_b_end_y = crd_type'(300);
      send_pair(p);
      p.seg_b_start_y = crd_type'(512);
      p.seg_b_end_y = crd_type'(511);
      send_pair(p);
      p = '0;
      p.seg_a_start_x = crd_type'(-100);
      p.seg_a_end_x = crd_type'(100);
      p.seg_b_start_y = crd_type'(-100);
      p.seg_b_end_y = crd_type'(100);
      send_pair(p);
      send_pair({hi, lo, hi, lo, hi, lo, hi, hi, lo, lo, lo, hi});

      // clearance extremes, random pairs at each
      write_limit('0);
      repeat (40) send_pair(rand_pair());
      write_limit(scp_pkg::DIST_MAX);
      repeat (40) send_pair(rand_pair());
      write_limit(scp_pkg::dist_type'(1));
      repeat (40) send_pair(rand_pair());

      // sender idles more lightly than the receiver
      write_limit(scp_pkg::dist_type'(2000));
      sender_idle_pct = 25;
      receiver_idle_pct = 49;
      repeat (300) send_pair(rand_pair());

      // the other way round
      write_limit(scp_pkg::dist_type'($urandom_range(5000)));
      sender_idle_pct = 49;
      receiver_idle_pct = 25;
      repeat (300) send_pair(rand_pair());

      // full rate, with one long receiver hold-off that backs up the pipe
      write_limit(scp_pkg::CLR_RESET);
      sender_idle_pct = 0;
      receiver_idle_pct = 0;
      long_stall_go = 1'b1;
      repeat (400) send_pair(rand_pair());
      req_valid <= 1'b0;

      while (results_pending != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (mismatch_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
